### hw/rtl/assert_macros.svh
// Assertion macros shared by the grid test pattern RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RGTP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define RGTP_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define RGTP_ASSERT(lbl, prop)
`define RGTP_ASSERT_NEVER(lbl, cond)
`endif
`endif

### hw/rtl/rgtp_pkg.sv
// Grid test pattern package: widths, register codes, word types and color helpers.
package rgtp_pkg;

    localparam int COORD_BITS    = 12;
    localparam int COORD_W       = 12;
    localparam int RES_W         = 13;
    localparam int RC_W          = 8;
    localparam int COLOR_W       = 32;
    localparam int STEP_W        = 8;
    localparam int MODE_W        = 2;
    localparam int BPP_W         = 6;
    localparam int LAYOUT_W      = 30;
    localparam int OFFSET_W      = 26;
    localparam int LIN_W         = 26;
    localparam int BYTES_W       = 4;
    localparam int TILE_W        = 16;
    localparam int AMT_W         = 17;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_STAGES    = 8;
    localparam int BYTE_BITS     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_H_RES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_RES   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BPP     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT  = 4'd7;

    localparam logic [MODE_W-1:0] MODE_INDEXED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIRECT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNSUPP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_in_word;

    typedef struct packed {
        logic                drawn;
        logic [COLOR_W-1:0]  pixel_color;
        logic [OFFSET_W-1:0] byte_offset;
        logic                config_error;
    } t_out_word;

    typedef struct packed {
        logic [RES_W-1:0]    h_resolution;
        logic [RES_W-1:0]    v_resolution;
        logic [RC_W-1:0]     rect_count;
        logic [COLOR_W-1:0]  base_color;
        logic [STEP_W-1:0]   color_step;
        logic [MODE_W-1:0]   pixel_mode;
        logic [BPP_W-1:0]    bits_per_pixel;
        logic [LAYOUT_W-1:0] channel_layout;
    } t_cfg;

    typedef struct packed {
        logic             busy;
        logic [RES_W-1:0] rect_w;
        logic [RES_W-1:0] rect_h;
        logic [RES_W-1:0] lim_x;
        logic [RES_W-1:0] lim_y;
    } t_geom;

    typedef struct packed {
        logic               drawn;
        logic               err;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LIN_W-1:0]   lin;
    } t_qword;

    function automatic logic [COLOR_W-1:0] low_mask(input logic [BPP_W-1:0] bpp);
        logic [COLOR_W-1:0] m;
        if (bpp >= BPP_W'(COLOR_W)) begin
            m = '1;
        end else begin
            m = (COLOR_W'(1) << bpp) - COLOR_W'(1);
        end
        return m;
    endfunction

    function automatic logic [COLOR_W-1:0] advance_channel(
        input logic [COLOR_W-1:0] first,
        input logic [4:0]         pos,
        input logic [4:0]         size,
        input logic [AMT_W-1:0]   amt
    );
        logic [COLOR_W-1:0] m;
        logic [COLOR_W-1:0] v;
        m = (COLOR_W'(1) << size) - COLOR_W'(1);
        v = (((first >> pos) & m) + COLOR_W'(amt)) & m;
        return v << pos;
    endfunction

endpackage

### hw/rtl/rgtp_cfg.sv
// Grid test pattern configuration registers and rectangle size divider.
module rgtp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgtp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rgtp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output rgtp_pkg::t_cfg                      o_cfg,
    output rgtp_pkg::t_geom                     o_geom
);
    localparam int RES_W = rgtp_pkg::RES_W;
    localparam int RC_W  = rgtp_pkg::RC_W;
    localparam int CNT_W = $clog2(RES_W + 1);

    rgtp_pkg::t_cfg     r_cfg;
    logic               r_restart;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_lim;
    logic [RES_W-1:0]   r_hq;
    logic [RES_W-1:0]   r_vq;
    logic [RC_W:0]      r_hr;
    logic [RC_W:0]      r_vr;
    logic [RES_W-1:0]   r_lim_x;
    logic [RES_W-1:0]   r_lim_y;

    logic [RC_W:0]      h_t;
    logic [RC_W:0]      v_t;
    logic               h_ge;
    logic               v_ge;
    logic [RC_W:0]      n_hr;
    logic [RC_W:0]      n_vr;
    logic [RES_W+RC_W-1:0] n_lim_x;
    logic [RES_W+RC_W-1:0] n_lim_y;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        h_t     = {r_hr[RC_W-1:0], r_hq[RES_W-1]};
        v_t     = {r_vr[RC_W-1:0], r_vq[RES_W-1]};
        h_ge    = h_t >= {1'b0, r_cfg.rect_count};
        v_ge    = v_t >= {1'b0, r_cfg.rect_count};
        n_hr    = h_ge ? h_t - {1'b0, r_cfg.rect_count} : h_t;
        n_vr    = v_ge ? v_t - {1'b0, r_cfg.rect_count} : v_t;
        n_lim_x = (RES_W+RC_W)'(r_hq) * (RES_W+RC_W)'(r_cfg.rect_count);
        n_lim_y = (RES_W+RC_W)'(r_vq) * (RES_W+RC_W)'(r_cfg.rect_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_resolution   <= RES_W'(1024);
            r_cfg.v_resolution   <= RES_W'(768);
            r_cfg.rect_count     <= RC_W'(1);
            r_cfg.base_color     <= '0;
            r_cfg.color_step     <= rgtp_pkg::STEP_W'(1);
            r_cfg.pixel_mode     <= rgtp_pkg::MODE_INDEXED;
            r_cfg.bits_per_pixel <= rgtp_pkg::BPP_W'(8);
            r_cfg.channel_layout <= '0;
            r_restart            <= 1'b1;
            r_cnt                <= '0;
            r_lim                <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rgtp_pkg::REG_H_RES:  r_cfg.h_resolution   <= i_cfg_data[RES_W-1:0];
                    rgtp_pkg::REG_V_RES:  r_cfg.v_resolution   <= i_cfg_data[RES_W-1:0];
                    rgtp_pkg::REG_RECT:   r_cfg.rect_count     <= i_cfg_data[RC_W-1:0];
                    rgtp_pkg::REG_FIRST:  r_cfg.base_color     <= i_cfg_data;
                    rgtp_pkg::REG_STEP:   r_cfg.color_step     <=
                        i_cfg_data[rgtp_pkg::STEP_W-1:0];
                    rgtp_pkg::REG_MODE:   r_cfg.pixel_mode     <=
                        i_cfg_data[rgtp_pkg::MODE_W-1:0];
                    rgtp_pkg::REG_BPP:    r_cfg.bits_per_pixel <=
                        i_cfg_data[rgtp_pkg::BPP_W-1:0];
                    rgtp_pkg::REG_LAYOUT: r_cfg.channel_layout <=
                        i_cfg_data[rgtp_pkg::LAYOUT_W-1:0];
                    default: ;
                endcase
            end
            r_restart <= i_cfg_valid;
            if (r_restart) begin
                r_cnt <= CNT_W'(RES_W);
                r_lim <= 1'b0;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_lim <= (r_cnt == CNT_W'(1));
            end else begin
                r_lim <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_restart) begin
            r_hq <= r_cfg.h_resolution;
            r_vq <= r_cfg.v_resolution;
            r_hr <= '0;
            r_vr <= '0;
        end else if (r_cnt != '0) begin
            r_hq <= {r_hq[RES_W-2:0], h_ge};
            r_vq <= {r_vq[RES_W-2:0], v_ge};
            r_hr <= n_hr;
            r_vr <= n_vr;
        end
        if (r_lim) begin
            r_lim_x <= n_lim_x[RES_W-1:0];
            r_lim_y <= n_lim_y[RES_W-1:0];
        end
    end

    assign o_cfg         = r_cfg;
    assign o_geom.busy   = r_restart | (r_cnt != '0) | r_lim;
    assign o_geom.rect_w = r_hq;
    assign o_geom.rect_h = r_vq;
    assign o_geom.lim_x  = r_lim_x;
    assign o_geom.lim_y  = r_lim_y;

endmodule

### hw/rtl/rgtp_front.sv
// Grid test pattern front end: input handshake, grid check and linear pixel index.
module rgtp_front #(
    parameter int P_COORD_BITS = rgtp_pkg::COORD_BITS
) (
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rgtp_pkg::t_in_word   i_in_word,
    input  rgtp_pkg::t_cfg       i_cfg,
    input  rgtp_pkg::t_geom      i_geom,
    input  logic                 i_q_full,
    output logic                 o_push,
    output rgtp_pkg::t_qword     o_qword
);
    localparam int COORD_W = rgtp_pkg::COORD_W;
    localparam int RES_W   = rgtp_pkg::RES_W;
    localparam int PROD_W  = COORD_W + RES_W;
    localparam logic [COORD_W-1:0] COORD_MASK =
        (P_COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
        COORD_W'((64'd1 << P_COORD_BITS) - 64'd1);

    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PROD_W-1:0]  y_row;
    logic               err;
    logic               in_grid;

    always_comb begin
        x       = i_in_word.pixel_x & COORD_MASK;
        y       = i_in_word.pixel_y & COORD_MASK;
        y_row   = PROD_W'(y) * PROD_W'(i_cfg.h_resolution);
        err     = (i_cfg.pixel_mode > rgtp_pkg::MODE_DIRECT) || (i_cfg.rect_count == '0);
        in_grid = (i_geom.rect_w != '0) && (i_geom.rect_h != '0)
               && (RES_W'(x) < i_geom.lim_x) && (RES_W'(y) < i_geom.lim_y);
        o_qword.drawn = !err && in_grid;
        o_qword.err   = err;
        o_qword.x     = x;
        o_qword.y     = y;
        o_qword.lin   = rgtp_pkg::LIN_W'(y_row) + rgtp_pkg::LIN_W'(x);
    end

    assign o_in_stall = i_geom.busy | i_q_full;
    assign o_push     = i_in_valid & !o_in_stall;

endmodule

### hw/rtl/rgtp_queue.sv
// Grid test pattern queue between front end and back end.
`include "assert_macros.svh"
module rgtp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rgtp_pkg::t_qword   i_word,
    input  logic               i_pop,
    output rgtp_pkg::t_qword   o_word,
    output logic               o_empty,
    output logic               o_full
);
    localparam int DEPTH = rgtp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgtp_pkg::t_qword  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    assign o_word  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    `RGTP_ASSERT(a_cnt_max, r_cnt <= CNT_W'(DEPTH))
    `RGTP_ASSERT_NEVER(a_pop_empty, i_pop && (r_cnt == '0))
    `RGTP_ASSERT_NEVER(a_push_full, i_push && !i_pop && (r_cnt == CNT_W'(DEPTH)))

endmodule

### hw/rtl/rgtp_back.sv
// Grid test pattern back end: tile divide pipeline, color build and output register.
`include "assert_macros.svh"
module rgtp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rgtp_pkg::t_cfg       i_cfg,
    input  rgtp_pkg::t_geom      i_geom,
    input  rgtp_pkg::t_qword     i_qword,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rgtp_pkg::t_out_word  o_out_word
);
    localparam int NS      = rgtp_pkg::DIV_STAGES;
    localparam int RES_W   = rgtp_pkg::RES_W;
    localparam int RC_W    = rgtp_pkg::RC_W;
    localparam int SH_W    = RES_W + NS;
    localparam int LIN_W   = rgtp_pkg::LIN_W;
    localparam int TILE_W  = rgtp_pkg::TILE_W;
    localparam int AMT_W   = rgtp_pkg::AMT_W;
    localparam int COLOR_W = rgtp_pkg::COLOR_W;
    localparam int OFF_W   = rgtp_pkg::OFFSET_W;
    localparam int BYTES_W = rgtp_pkg::BYTES_W;
    localparam int MUL_W   = LIN_W + BYTES_W;

    typedef struct packed {
        logic              drawn;
        logic              err;
        logic [LIN_W-1:0]  lin;
        logic [RES_W-1:0]  xr;
        logic [RES_W-1:0]  yr;
        logic [RC_W-1:0]   col;
        logic [RC_W-1:0]   row;
    } t_dstage;

    typedef struct packed {
        logic              drawn;
        logic              err;
        logic [RC_W-1:0]   col;
        logic [RC_W-1:0]   row;
        logic [TILE_W-1:0] tile;
        logic [OFF_W-1:0]  off;
    } t_tstage;

    typedef struct packed {
        logic               drawn;
        logic               err;
        logic [OFF_W-1:0]   off;
        logic [COLOR_W-1:0] idx;
        logic [AMT_W-1:0]   pr;
        logic [AMT_W-1:0]   pg;
        logic [AMT_W-1:0]   pb;
    } t_pstage;

    logic                 en;
    logic [NS:0]          r_dv;
    t_dstage              r_d [NS+1];
    t_dstage              n_d [NS+1];
    logic                 r_tv;
    t_tstage              r_t;
    t_tstage              n_t;
    logic                 r_pv;
    t_pstage              r_p;
    t_pstage              n_p;
    logic                 r_ov;
    rgtp_pkg::t_out_word  r_o;
    rgtp_pkg::t_out_word  n_o;
    logic [BYTES_W-1:0]   bytes;
    logic [MUL_W-1:0]     off_full;
    logic [COLOR_W-1:0]   chan;
    logic [COLOR_W-1:0]   color;
    logic                 x_ge;
    logic                 y_ge;

    assign en    = !r_ov || !i_out_stall;
    assign o_pop = en && !i_q_empty;

    always_comb begin
        n_d[0].drawn = i_qword.drawn;
        n_d[0].err   = i_qword.err;
        n_d[0].lin   = i_qword.lin;
        n_d[0].xr    = RES_W'(i_qword.x);
        n_d[0].yr    = RES_W'(i_qword.y);
        n_d[0].col   = '0;
        n_d[0].row   = '0;
        x_ge = 1'b0;
        y_ge = 1'b0;
        for (int k = 0; k < NS; k++) begin
            n_d[k+1] = r_d[k];
            x_ge = SH_W'(r_d[k].xr) >= (SH_W'(i_geom.rect_w) << (NS - 1 - k));
            y_ge = SH_W'(r_d[k].yr) >= (SH_W'(i_geom.rect_h) << (NS - 1 - k));
            if (x_ge) begin
                n_d[k+1].xr = r_d[k].xr
                            - RES_W'(SH_W'(i_geom.rect_w) << (NS - 1 - k));
            end
            if (y_ge) begin
                n_d[k+1].yr = r_d[k].yr
                            - RES_W'(SH_W'(i_geom.rect_h) << (NS - 1 - k));
            end
            n_d[k+1].col = {r_d[k].col[RC_W-2:0], x_ge};
            n_d[k+1].row = {r_d[k].row[RC_W-2:0], y_ge};
        end
    end

    always_comb begin
        bytes    = BYTES_W'((7'(i_cfg.bits_per_pixel)
                 + 7'(rgtp_pkg::BYTE_BITS - 1)) >> 3);
        off_full = MUL_W'(r_d[NS].lin) * MUL_W'(bytes);
        n_t.drawn = r_d[NS].drawn;
        n_t.err   = r_d[NS].err;
        n_t.col   = r_d[NS].col;
        n_t.row   = r_d[NS].row;
        n_t.tile  = TILE_W'(r_d[NS].row) * TILE_W'(i_cfg.rect_count)
                  + TILE_W'(r_d[NS].col);
        n_t.off   = off_full[OFF_W-1:0];
    end

    always_comb begin
        n_p.drawn = r_t.drawn;
        n_p.err   = r_t.err;
        n_p.off   = r_t.off;
        n_p.idx   = i_cfg.base_color
                  + COLOR_W'(24'(r_t.tile) * 24'(i_cfg.color_step));
        n_p.pr    = AMT_W'(r_t.col) * AMT_W'(i_cfg.color_step);
        n_p.pg    = AMT_W'(r_t.row) * AMT_W'(i_cfg.color_step);
        n_p.pb    = (AMT_W'(r_t.col) + AMT_W'(r_t.row)) * AMT_W'(i_cfg.color_step);
    end

    always_comb begin
        chan = rgtp_pkg::advance_channel(i_cfg.base_color,
                   i_cfg.channel_layout[4:0], i_cfg.channel_layout[9:5], r_p.pr)
             | rgtp_pkg::advance_channel(i_cfg.base_color,
                   i_cfg.channel_layout[14:10], i_cfg.channel_layout[19:15], r_p.pg)
             | rgtp_pkg::advance_channel(i_cfg.base_color,
                   i_cfg.channel_layout[24:20], i_cfg.channel_layout[29:25], r_p.pb);
        color = (i_cfg.pixel_mode == rgtp_pkg::MODE_INDEXED) ? r_p.idx : chan;
        n_o.drawn        = r_p.drawn;
        n_o.pixel_color  = r_p.drawn ? (color & rgtp_pkg::low_mask(i_cfg.bits_per_pixel))
                                     : '0;
        n_o.byte_offset  = r_p.off;
        n_o.config_error = r_p.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_tv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= {r_dv[NS-1:0], o_pop};
            r_tv <= r_dv[NS];
            r_pv <= r_tv;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NS; k++) begin
                r_d[k] <= n_d[k];
            end
            r_t <= n_t;
            r_p <= n_p;
            r_o <= n_o;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_o;

    `RGTP_ASSERT_NEVER(a_undrawn_color, r_ov && !r_o.drawn && (r_o.pixel_color != '0))
    `RGTP_ASSERT_NEVER(a_err_drawn, r_ov && r_o.config_error && r_o.drawn)
    `RGTP_ASSERT_NEVER(a_pop_stalled, o_pop && r_ov && i_out_stall)

endmodule

### hw/rtl/rect_grid_test_pattern_core.sv
// Grid test pattern core: one pixel coordinate in, one pattern word out per clock.
// The block takes one pixel word per clock unless its input is stalled and
// delivers one result word per clock when the output is not stalled, through one
// queue slot, tile divide pipeline, two multiply stages and output register.
// Column and row come from an eight-stage divide pipeline, one quotient bit per
// stage. After reset and after every configuration write the input is stalled
// while a bit-serial divider works out the rectangle size, one bit per cycle over
// 13 bits. A four-word queue sits between the front end and the back end.
module rect_grid_test_pattern_core #(
    parameter int P_COORD_BITS = rgtp_pkg::COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rgtp_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rgtp_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgtp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgtp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    rgtp_pkg::t_cfg    cfg;
    rgtp_pkg::t_geom   geom;
    rgtp_pkg::t_qword  push_word;
    rgtp_pkg::t_qword  head_word;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;

    rgtp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_geom      (geom)
    );

    rgtp_front #(
        .P_COORD_BITS (P_COORD_BITS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_cfg      (cfg),
        .i_geom     (geom),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_qword    (push_word)
    );

    rgtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rgtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_geom      (geom),
        .i_qword     (head_word),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the grid test pattern core: directed table, random configs and pixels.
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;

    typedef struct {
        logic [rgtp_pkg::COORD_W-1:0] x;
        logic [rgtp_pkg::COORD_W-1:0] y;
        bit                           typed;
        rgtp_pkg::t_out_word          want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    rgtp_pkg::t_in_word              i_in_word;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    rgtp_pkg::t_out_word             o_out_word;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [rgtp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rgtp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rgtp_pkg::t_cfg      regs;
    rgtp_pkg::t_out_word pending_pixels[$];
    int        send_idle_pct;
    int        stall_pct;
    int        cycles = 0;
    int        errors = 0;
    int        pixels_sent;
    int        pixels_checked = 0;
    int        configs_run;

    rect_grid_test_pattern_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [rgtp_pkg::COLOR_W-1:0] shift_channel(rgtp_pkg::t_cfg c,
                                                                   int k,
                                                                   logic [31:0] amt);
        logic [4:0]  pos;
        logic [4:0]  size;
        logic [31:0] m;
        logic [31:0] v;
        pos  = c.channel_layout[10*k +: 5];
        size = c.channel_layout[10*k+5 +: 5];
        m    = (32'd1 << size) - 32'd1;
        v    = (((c.base_color >> pos) & m) + amt * 32'(c.color_step)) & m;
        return v << pos;
    endfunction

    function automatic rgtp_pkg::t_out_word pattern_at(rgtp_pkg::t_cfg c,
                                                       logic [rgtp_pkg::COORD_W-1:0] x,
                                                       logic [rgtp_pkg::COORD_W-1:0] y);
        int unsigned nbytes;
        logic [63:0] off;
        logic [31:0] rw;
        logic [31:0] rh;
        logic [31:0] rc;
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] color;
        logic        err;
        logic        drawn;
        rgtp_pkg::t_out_word r;
        nbytes = (int'(c.bits_per_pixel) + 7) / rgtp_pkg::BYTE_BITS;
        off    = 64'(nbytes) * (64'(x) + 64'(y) * 64'(c.h_resolution));
        err    = (c.pixel_mode > rgtp_pkg::MODE_DIRECT) || (c.rect_count == 0);
        drawn  = 1'b0;
        color  = '0;
        if (!err) begin
            rc = 32'(c.rect_count);
            rw = 32'(c.h_resolution) / rc;
            rh = 32'(c.v_resolution) / rc;
            if (rw != 0 && rh != 0 && 32'(x) < rw * rc && 32'(y) < rh * rc) begin
                col   = 32'(x) / rw;
                row   = 32'(y) / rh;
                drawn = 1'b1;
                if (c.pixel_mode == rgtp_pkg::MODE_INDEXED) begin
                    color = c.base_color + (row * rc + col) * 32'(c.color_step);
                end else begin
                    color = shift_channel(c, 0, col) | shift_channel(c, 1, row)
                          | shift_channel(c, 2, col + row);
                end
                if (c.bits_per_pixel < 32) begin
                    color &= (32'd1 << c.bits_per_pixel) - 32'd1;
                end
            end
        end
        r.drawn        = drawn;
        r.pixel_color  = color;
        r.byte_offset  = off[rgtp_pkg::OFFSET_W-1:0];
        r.config_error = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver side: random stall, check each accepted word
    always @(posedge i_clk) begin
        rgtp_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected word %h", o_out_word);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (o_out_word.drawn !== want.drawn) begin
                    $error("drawn: expected %h actual %h", want.drawn, o_out_word.drawn);
                    errors++;
                end
                if (o_out_word.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %h actual %h",
                           want.pixel_color, o_out_word.pixel_color);
                    errors++;
                end
                if (o_out_word.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %h actual %h",
                           want.byte_offset, o_out_word.byte_offset);
                    errors++;
                end
                if (o_out_word.config_error !== want.config_error) begin
                    $error("config_error: expected %h actual %h",
                           want.config_error, o_out_word.config_error);
                    errors++;
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic cfg_load(rgtp_pkg::t_cfg c);
        logic [rgtp_pkg::CFG_DATA_W-1:0] vals[8];
        vals[rgtp_pkg::REG_H_RES]  = 32'(c.h_resolution);
        vals[rgtp_pkg::REG_V_RES]  = 32'(c.v_resolution);
        vals[rgtp_pkg::REG_RECT]   = 32'(c.rect_count);
        vals[rgtp_pkg::REG_FIRST]  = c.base_color;
        vals[rgtp_pkg::REG_STEP]   = 32'(c.color_step);
        vals[rgtp_pkg::REG_MODE]   = 32'(c.pixel_mode);
        vals[rgtp_pkg::REG_BPP]    = 32'(c.bits_per_pixel);
        vals[rgtp_pkg::REG_LAYOUT] = 32'(c.channel_layout);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= rgtp_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        regs = c;
        configs_run++;
    endtask

    task automatic send_pixel(logic [rgtp_pkg::COORD_W-1:0] x,
                              logic [rgtp_pkg::COORD_W-1:0] y);
        rgtp_pkg::t_in_word w;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        w.pixel_x = x;
        w.pixel_y = y;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_pixels.push_back(pattern_at(regs, x, y));
        pixels_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic rgtp_pkg::t_cfg random_cfg;
        rgtp_pkg::t_cfg c;
        c.h_resolution   = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 1) ? 1 : 4096)
                                                       : 13'($urandom_range(1, 4096));
        c.v_resolution   = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 1) ? 1 : 4096)
                                                       : 13'($urandom_range(1, 4096));
        case ($urandom_range(0, 9))
            0:       c.rect_count = 8'd0;
            1:       c.rect_count = 8'd255;
            2:       c.rect_count = 8'($urandom_range(0, 255));
            default: c.rect_count = 8'($urandom_range(1, 16));
        endcase
        c.base_color     = $urandom();
        c.color_step     = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       c.pixel_mode = rgtp_pkg::MODE_UNSUPP;
            1:       c.pixel_mode = rgtp_pkg::MODE_RESERVED;
            2, 3, 4: c.pixel_mode = rgtp_pkg::MODE_INDEXED;
            default: c.pixel_mode = rgtp_pkg::MODE_DIRECT;
        endcase
        c.bits_per_pixel = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'(8 * $urandom_range(1, 4));
        if ($urandom_range(0, 1)) begin
            c.channel_layout = {5'(8), 5'(16), 5'(8), 5'(8), 5'(8), 5'(0)};
        end else begin
            c.channel_layout = 30'($urandom());
        end
        return c;
    endfunction

    t_row rows[$];
    rgtp_pkg::t_cfg c;
    int   lim_x;
    int   lim_y;

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        pixels_sent   = 0;
        configs_run   = 0;
        regs = '{h_resolution: 13'd1024, v_resolution: 13'd768, rect_count: 8'd1,
                 base_color: 32'd0, color_step: 8'd1, pixel_mode: rgtp_pkg::MODE_INDEXED,
                 bits_per_pixel: 6'd8, channel_layout: 30'd0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{12'd0, 12'd0, 1'b1, '{1'b1, 32'd0, 26'd0, 1'b0}});
        rows.push_back('{12'd1023, 12'd767, 1'b1, '{1'b1, 32'd0, 26'd786431, 1'b0}});
        rows.push_back('{12'd1024, 12'd0, 1'b1, '{1'b0, 32'd0, 26'd1024, 1'b0}});
        rows.push_back('{12'd0, 12'd768, 1'b1, '{1'b0, 32'd0, 26'd786432, 1'b0}});
        rows.push_back('{12'd4095, 12'd4095, 1'b1, '{1'b0, 32'd0, 26'd4197375, 1'b0}});
        foreach (rows[i]) begin
            send_pixel(rows[i].x, rows[i].y);
            if (rows[i].typed) begin
                pending_pixels[pending_pixels.size()-1] = rows[i].want;
            end
        end
        drain();

        // error, tiny grid, depth extremes, high channel fields, all-max, 24-bit direct layout
        for (int k = 0; k < 6; k++) begin
            c = regs;
            case (k)
                0: c.rect_count = 8'd0;
                1: begin c.pixel_mode = rgtp_pkg::MODE_RESERVED; c.rect_count = 8'd4; end
                2: begin c.pixel_mode = rgtp_pkg::MODE_INDEXED; c.h_resolution = 13'd100;
                         c.rect_count = 8'd255; c.bits_per_pixel = 6'd0; end
                3: begin c.h_resolution = 13'd4096; c.v_resolution = 13'd4096;
                         c.rect_count = 8'd255; c.base_color = '1; c.color_step = 8'd255;
                         c.bits_per_pixel = 6'd63; end
                4: begin c.pixel_mode = rgtp_pkg::MODE_DIRECT; c.rect_count = 8'd16;
                         c.bits_per_pixel = 6'd32; c.channel_layout = '1; end
                default: begin c.pixel_mode = rgtp_pkg::MODE_DIRECT; c.bits_per_pixel = 6'd24;
                         c.channel_layout = {5'(8), 5'(16), 5'(8), 5'(8), 5'(8), 5'(0)}; end
            endcase
            cfg_load(c);
            send_pixel(12'd0, 12'd0);
            send_pixel(12'd4095, 12'd4095);
            send_pixel(12'(c.h_resolution - 1), 12'(c.v_resolution - 1));
            send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            drain();
        end

        for (int ph = 0; ph < 17; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            cfg_load(random_cfg());
            lim_x = (regs.h_resolution > 4096) ? 4096 : int'(regs.h_resolution);
            lim_y = (regs.v_resolution > 4096) ? 4096 : int'(regs.v_resolution);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_pixel(12'($urandom_range(0, lim_x - 1)),
                               12'($urandom_range(0, lim_y - 1)));
                end else begin
                    send_pixel(12'($urandom()), 12'($urandom()));
                end
            end
            drain();
        end
        stall_pct = 0;

        $display("%0d pixels checked over %0d register settings", pixels_checked, configs_run);
        $display("indexed, direct and error modes, all idle and stall mixes");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
